@@ rtl/pwm_melody_sequencer_assert.svh @@
// Assertion macros used by the sequencer RTL.
`ifndef PWM_MELODY_SEQUENCER_ASSERT_SVH
`define PWM_MELODY_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define PMS_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("assertion failed");
`define PMS_ASSERT_NXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define PMS_ASSERT_IMP(label, clk, rst_n, cond, expr)
`define PMS_ASSERT_NXT(label, clk, rst_n, cond, expr)
`endif

`endif

@@ rtl/pms_pkg.sv @@
`timescale 1ns / 1ps

package pms_pkg;

    localparam int TABLE_DEPTH = 96;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W     = 32;

    localparam int                QUO_W   = $clog2(1000000 + 1);
    localparam int                CNT_W   = $clog2(QUO_W + 1);
    localparam logic [QUO_W-1:0]  TICK_HZ = QUO_W'(1000000);

    localparam logic [15:0] BEEP_DEFAULT_HZ = 16'd2304;
    localparam logic [16:0] PERIOD_MAX      = 17'd65536;
    localparam logic [16:0] PERIOD_MIN      = 17'd2;
    localparam logic [15:0] RELOAD_RESET    = 16'd999;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_PLAY = 2'd2;
    localparam logic [1:0] CMD_BEEP = 2'd3;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_REST = 2'd1;
    localparam logic [1:0] WR_TONE = 2'd2;

    typedef struct packed {
        logic        start;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/pwm_melody_sequencer.sv @@
// Channel   Handshake           Payload
// input     i_valid / o_ready   i_command, i_now_ms, i_note_index, i_note_freq,
//                               i_note_dur, i_note_count
// output    o_valid / i_ready   o_timer_write, o_reload_value, o_compare_value,
//                               o_playing
//
// A load or a tick without a note change goes straight to the done state; a rest
// may pass the read and tone states first. A new tone waits on the bit-per-cycle divider.
// Reset clears the player state; the note table is not cleared.
// A new item is taken while a result waits; it completes once that result leaves.
`timescale 1ns / 1ps

`include "pwm_melody_sequencer_assert.svh"

module pwm_melody_sequencer
    import pms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_now_ms,
    input  logic [6:0]  i_note_index,
    input  logic [15:0] i_note_freq,
    input  logic [15:0] i_note_dur,
    input  logic [7:0]  i_note_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_timer_write,
    output logic [15:0] o_reload_value,
    output logic [15:0] o_compare_value,
    output logic        o_playing
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TONE = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state, n_state;
    logic        r_active, n_active;
    logic [7:0]  r_notes, n_notes;
    logic [7:0]  r_pos, n_pos;
    logic [31:0] r_last, n_last;
    logic [31:0] r_end, n_end;
    logic [15:0] r_reload, n_reload;
    logic [15:0] r_compare, n_compare;
    logic [15:0] r_freq, n_freq;
    logic [1:0]  r_write, n_write;
    logic        r_o_valid, n_o_valid;
    logic [1:0]  r_o_write, n_o_write;
    logic [15:0] r_o_reload, n_o_reload;
    logic [15:0] r_o_compare, n_o_compare;
    logic        r_o_playing, n_o_playing;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic [7:0]  new_pos;
    logic [31:0] tick_diff;
    logic        melody_over;
    logic [7:0]  index_ext;
    logic [15:0] beep_freq;
    logic [16:0] period;
    logic [16:0] period_m1;

    pms_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH),
        .AW   (ADDR_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pms_divider u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        new_pos     = r_pos + 8'd1;
        tick_diff   = i_now_ms - r_end;
        melody_over = ({1'b0, new_pos} >= {1'b0, r_notes}) ||
                      ({1'b0, new_pos} >= 9'(TABLE_DEPTH));
        index_ext   = {1'b0, i_note_index};
        beep_freq   = (i_note_freq == 16'd0) ? BEEP_DEFAULT_HZ : i_note_freq;

        if ({3'd0, div_rsp.quotient} < 23'(PERIOD_MIN)) begin
            period = PERIOD_MIN;
        end else if ({3'd0, div_rsp.quotient} > 23'(PERIOD_MAX)) begin
            period = PERIOD_MAX;
        end else begin
            period = div_rsp.quotient[16:0];
        end
        period_m1 = period - 17'd1;

        ram_we    = 1'b0;
        ram_waddr = (i_command == CMD_BEEP) ? '0 : index_ext[ADDR_W-1:0];
        ram_wdata = (i_command == CMD_BEEP) ? {beep_freq, i_note_dur}
                                            : {i_note_freq, i_note_dur};
        ram_raddr = (i_command == CMD_PLAY) ? '0 : new_pos[ADDR_W-1:0];

        div_req.start   = 1'b0;
        div_req.divisor = r_freq;

        n_state     = r_state;
        n_active    = r_active;
        n_notes     = r_notes;
        n_pos       = r_pos;
        n_last      = r_last;
        n_end       = r_end;
        n_reload    = r_reload;
        n_compare   = r_compare;
        n_freq      = r_freq;
        n_write     = r_write;
        n_o_valid   = r_o_valid;
        n_o_write   = r_o_write;
        n_o_reload  = r_o_reload;
        n_o_compare = r_o_compare;
        n_o_playing = r_o_playing;

        if (i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_write = WR_NONE;
                    n_state = S_DONE;
                    case (i_command)
                        CMD_TICK: begin
                            n_last = i_now_ms;
                            if (r_active && !tick_diff[31]) begin
                                n_pos = new_pos;
                                if (melody_over) begin
                                    n_compare = 16'd0;
                                    n_write   = WR_REST;
                                    n_active  = 1'b0;
                                end else begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        CMD_LOAD: begin
                            if (index_ext < 8'(TABLE_DEPTH)) begin
                                ram_we = 1'b1;
                            end
                        end
                        CMD_PLAY: begin
                            if (i_note_count == 8'd0) begin
                                n_compare = 16'd0;
                                n_write   = WR_REST;
                                n_active  = 1'b0;
                            end else begin
                                n_notes  = ({1'b0, i_note_count} > 9'(TABLE_DEPTH))
                                           ? 8'(TABLE_DEPTH) : i_note_count;
                                n_pos    = 8'd0;
                                n_active = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                        CMD_BEEP: begin
                            if (i_note_dur != 16'd0) begin
                                ram_we   = 1'b1;
                                n_notes  = 8'd1;
                                n_pos    = 8'd0;
                                n_active = 1'b1;
                                n_end    = r_last + {16'd0, i_note_dur};
                                n_freq   = beep_freq;
                                n_state  = S_TONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_end   = r_last + {16'd0, ram_rdata[15:0]};
                n_freq  = ram_rdata[31:16];
                n_state = S_TONE;
            end
            S_TONE: begin
                if (r_freq == 16'd0) begin
                    n_compare = 16'd0;
                    n_write   = WR_REST;
                    n_state   = S_DONE;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_reload  = period_m1[15:0];
                    n_compare = period[16:1];
                    n_write   = WR_TONE;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid   = 1'b1;
                    n_o_write   = r_write;
                    n_o_reload  = r_reload;
                    n_o_compare = r_compare;
                    n_o_playing = r_active;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= 1'b0;
            r_notes   <= 8'd0;
            r_pos     <= 8'd0;
            r_last    <= 32'd0;
            r_end     <= 32'd0;
            r_reload  <= RELOAD_RESET;
            r_compare <= 16'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_notes   <= n_notes;
            r_pos     <= n_pos;
            r_last    <= n_last;
            r_end     <= n_end;
            r_reload  <= n_reload;
            r_compare <= n_compare;
            r_o_valid <= n_o_valid;
        end
        r_freq      <= n_freq;
        r_write     <= n_write;
        r_o_write   <= n_o_write;
        r_o_reload  <= n_o_reload;
        r_o_compare <= n_o_compare;
        r_o_playing <= n_o_playing;
    end

    assign o_valid         = r_o_valid;
    assign o_timer_write   = r_o_write;
    assign o_reload_value  = r_o_reload;
    assign o_compare_value = r_o_compare;
    assign o_playing       = r_o_playing;

    // An accepted transfer leaves the block busy in the cycle after it.
    `PMS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, r_state != S_IDLE)
    // A tone is only computed for an active melody or beep.
    `PMS_ASSERT_IMP(a_div_active, i_clk, i_rst_n, r_state == S_DIV, r_active)
    // While playing, the position stays inside the melody.
    `PMS_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, r_active, r_pos < r_notes)

endmodule

@@ rtl/pms_ram.sv @@
`timescale 1ns / 1ps

module pms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pms_divider.sv @@
`timescale 1ns / 1ps

module pms_divider
    import pms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [15:0]      r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [15:0]      r_div, n_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [16:0]      shifted;
    logic [16:0]      diff;

    always_comb begin
        shifted = {r_rem, r_quo[QUO_W-1]};
        diff    = shifted - {1'b0, r_div};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_rem = 16'd0;
            n_quo = TICK_HZ;
            n_div = i_req.divisor;
            n_cnt = CNT_W'(QUO_W);
        end else if (r_cnt != '0) begin
            if (shifted >= {1'b0, r_div}) begin
                n_rem = diff[15:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[15:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
